[rtl/ffa_pkg.sv]
// package: sizes, payload types and codes of the free list allocator
package ffa_pkg;

  localparam int unsigned ENTRIES = 1024;
  localparam int unsigned AW      = $clog2(ENTRIES);
  localparam int unsigned CW      = $clog2(ENTRIES + 1);

  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  typedef enum logic [1:0] {
    KIND_ALLOC      = 2'd0,
    KIND_RELEASE    = 2'd1,
    KIND_ALLOC_PG   = 2'd2,
    KIND_RELEASE_PG = 2'd3
  } kind_e;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
  } region_t;

  localparam int unsigned RW = $bits(region_t);

endpackage

[rtl/ffa_if.sv]
// channel interfaces: request beat and response beat
interface ffa_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] address;
  logic [31:0] length;
  modport source (output valid, kind, address, length, input ready);
  modport sink   (input valid, kind, address, length, output ready);
endinterface

interface ffa_rsp_if;
  logic                   valid;
  logic                   ready;
  logic [31:0]            result_addr;
  logic                   status;
  logic [31:0]            total_free;
  logic [ffa_pkg::CW-1:0] regions_now;
  logic [ffa_pkg::CW-1:0] regions_peak;
  logic [31:0]            lost_regions;
  logic [31:0]            lost_bytes_total;
  modport source (output valid, result_addr, status, total_free, regions_now,
                  regions_peak, lost_regions, lost_bytes_total, input ready);
  modport sink   (input valid, result_addr, status, total_free, regions_now,
                  regions_peak, lost_regions, lost_bytes_total, output ready);
endinterface

[rtl/ffa_ram.sv]
// generic single port ram with registered read
module ffa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[rtl/first_fit_free_list_allocator.sv]
// first-fit free list allocator: sequencer over an address-sorted region ram
// A request walks the table one entry at a time (read, then compare), and a
// drop or insert moves each later entry in turn (read, then write).
// One item at a time over the single-port region ram; requests are taken in S_IDLE.
// Reset: counters and totals clear at once; the region ram is not cleared.
module first_fit_free_list_allocator (
  input  logic          clk_i,
  input  logic          rst_ni,
  ffa_req_if.sink       req,
  ffa_rsp_if.source     rsp
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_RD   = 10'b00_0000_0010,
    S_EV   = 10'b00_0000_0100,
    S_REL  = 10'b00_0000_1000,
    S_DRD  = 10'b00_0001_0000,
    S_DWR  = 10'b00_0010_0000,
    S_SRD  = 10'b00_0100_0000,
    S_SWR  = 10'b00_1000_0000,
    S_INS  = 10'b01_0000_0000,
    S_FIN  = 10'b10_0000_0000
  } state_e;

  localparam int unsigned CW = ffa_pkg::CW;
  localparam int unsigned AW = ffa_pkg::AW;
  localparam logic [CW-1:0] FULL = CW'(ffa_pkg::ENTRIES);

  state_e state_q, state_d;
  logic             rel_q, rel_d;
  logic [31:0]      addr_q, addr_d;
  logic [31:0]      len_q, len_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    mv_q, mv_d;
  ffa_pkg::region_t prev_q, prev_d;
  ffa_pkg::region_t cur_q, cur_d;
  logic [31:0]      res_q, res_d;
  logic             st_q, st_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    peak_q, peak_d;
  logic [31:0]      lost_q, lost_d;
  logic [31:0]      lostb_q, lostb_d;
  logic [31:0]      free_q, free_d;
  logic             ov_q, ov_d;

  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  ffa_pkg::region_t ram_wdata, ram_rdata;

  logic [31:0]      in_len;
  logic             cur_ok, prev_ok;
  logic [31:0]      merged;

  ffa_ram #(
    .WIDTH (ffa_pkg::RW),
    .DEPTH (ffa_pkg::ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign req.ready = (state_q == S_IDLE);

  // page rounding of the incoming length
  always_comb begin
    if (req.kind[1]) begin
      in_len = (req.length + ffa_pkg::PAGE_ADD) & ffa_pkg::PAGE_MASK;
    end else begin
      in_len = req.length;
    end
  end

  // neighbour checks for a release
  assign cur_ok  = (idx_q < count_q) && ((addr_q + len_q) == cur_q.base);
  assign prev_ok = (idx_q != '0) && ((prev_q.base + prev_q.size) == addr_q);
  assign merged  = prev_q.size + len_q + (cur_ok ? cur_q.size : 32'd0);

  // sequencer
  always_comb begin
    state_d   = state_q;
    rel_d     = rel_q;
    addr_d    = addr_q;
    len_d     = len_q;
    idx_d     = idx_q;
    mv_d      = mv_q;
    prev_d    = prev_q;
    cur_d     = cur_q;
    res_d     = res_q;
    st_d      = st_q;
    count_d   = count_q;
    peak_d    = peak_q;
    lost_d    = lost_q;
    lostb_d   = lostb_q;
    free_d    = free_q;
    ov_d      = ov_q;
    ram_we    = 1'b0;
    ram_addr  = idx_q[AW-1:0];
    ram_wdata = ram_rdata;

    // response beat taken
    if (rsp.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          rel_d   = req.kind[0];
          addr_d  = req.address;
          len_d   = in_len;
          idx_d   = '0;
          res_d   = '0;
          st_d    = 1'b0;
          state_d = S_RD;
        end
      end
      // issue read of entry idx, or end of table
      S_RD: begin
        if (idx_q >= count_q) begin
          state_d = rel_q ? S_REL : S_FIN;
        end else begin
          state_d = S_EV;
        end
      end
      // compare the entry just read
      S_EV: begin
        if (!rel_q) begin
          if (ram_rdata.size >= len_q) begin
            ram_we         = 1'b1;
            ram_wdata.base = ram_rdata.base + len_q;
            ram_wdata.size = ram_rdata.size - len_q;
            res_d          = ram_rdata.base;
            free_d         = free_q - len_q;
            if (ram_rdata.size == len_q) begin
              count_d = count_q - 1'b1;
              mv_d    = idx_q;
              state_d = S_DRD;
            end else begin
              state_d = S_FIN;
            end
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end else begin
          if (ram_rdata.base > addr_q) begin
            cur_d   = ram_rdata;
            state_d = S_REL;
          end else begin
            prev_d  = ram_rdata;
            idx_d   = idx_q + 1'b1;
            state_d = S_RD;
          end
        end
      end
      // release decision: merge, insert or lose
      S_REL: begin
        if (prev_ok) begin
          ram_we         = 1'b1;
          ram_addr       = AW'(idx_q - 1'b1);
          ram_wdata.base = prev_q.base;
          ram_wdata.size = merged;
          free_d         = free_q + len_q;
          if (cur_ok) begin
            count_d = count_q - 1'b1;
            mv_d    = idx_q;
            state_d = S_DRD;
          end else begin
            state_d = S_FIN;
          end
        end else if (cur_ok) begin
          ram_we         = 1'b1;
          ram_wdata.base = addr_q;
          ram_wdata.size = cur_q.size + len_q;
          free_d         = free_q + len_q;
          state_d        = S_FIN;
        end else if (count_q < FULL) begin
          free_d  = free_q + len_q;
          mv_d    = count_q;
          state_d = S_SRD;
        end else begin
          lost_d  = lost_q + 32'd1;
          lostb_d = lostb_q + len_q;
          st_d    = 1'b1;
          state_d = S_FIN;
        end
      end
      // close the gap: entry mv+1 moves to mv
      S_DRD: begin
        ram_addr = AW'(mv_q + 1'b1);
        if (mv_q < count_q) begin
          state_d = S_DWR;
        end else begin
          state_d = S_FIN;
        end
      end
      S_DWR: begin
        ram_we   = 1'b1;
        ram_addr = mv_q[AW-1:0];
        mv_d     = mv_q + 1'b1;
        state_d  = S_DRD;
      end
      // open a gap: entry mv-1 moves to mv
      S_SRD: begin
        ram_addr = AW'(mv_q - 1'b1);
        if (mv_q > idx_q) begin
          state_d = S_SWR;
        end else begin
          state_d = S_INS;
        end
      end
      S_SWR: begin
        ram_we   = 1'b1;
        ram_addr = mv_q[AW-1:0];
        mv_d     = mv_q - 1'b1;
        state_d  = S_SRD;
      end
      S_INS: begin
        ram_we         = 1'b1;
        ram_wdata.base = addr_q;
        ram_wdata.size = len_q;
        count_d        = count_q + 1'b1;
        if (peak_q < count_q + 1'b1) begin
          peak_d = count_q + 1'b1;
        end
        state_d        = S_FIN;
      end
      // hand over the result once the output register is free
      S_FIN: begin
        if (!ov_q || rsp.ready) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      peak_q  <= '0;
      lost_q  <= '0;
      lostb_q <= '0;
      free_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      peak_q  <= peak_d;
      lost_q  <= lost_d;
      lostb_q <= lostb_d;
      free_q  <= free_d;
      ov_q    <= ov_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rel_q  <= rel_d;
    addr_q <= addr_d;
    len_q  <= len_d;
    idx_q  <= idx_d;
    mv_q   <= mv_d;
    prev_q <= prev_d;
    cur_q  <= cur_d;
    res_q  <= res_d;
    st_q   <= st_d;
  end

  // output beat register, loaded when the item finishes
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && (!ov_q || rsp.ready)) begin
      rsp.result_addr      <= res_q;
      rsp.status           <= st_q;
      rsp.total_free       <= free_q;
      rsp.regions_now      <= count_q;
      rsp.regions_peak     <= peak_q;
      rsp.lost_regions     <= lost_q;
      rsp.lost_bytes_total <= lostb_q;
    end
  end

  assign rsp.valid = ov_q;

endmodule

[sim/tb_top.sv]
// testbench: first-fit free list allocator against a behavioural free table
`timescale 1ns / 100ps

module tb_top;

  typedef struct {
    logic [31:0]            addr;
    logic                   st;
    logic [31:0]            free;
    logic [ffa_pkg::CW-1:0] now;
    logic [ffa_pkg::CW-1:0] peak;
    logic [31:0]            lost_n;
    logic [31:0]            lost_b;
  } outcome_t;

  typedef struct {
    logic [31:0] base;
    logic [31:0] len;
  } block_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ffa_req_if req ();
  ffa_rsp_if rsp ();

  first_fit_free_list_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp)
  );

  always #5 clk_i = ~clk_i;

  // behavioural copy of the free table
  logic [31:0] fl_base [ffa_pkg::ENTRIES];
  logic [31:0] fl_size [ffa_pkg::ENTRIES];
  int unsigned fl_cnt   = 0;
  int unsigned fl_peak  = 0;
  logic [31:0] lost_n   = '0;
  logic [31:0] lost_b   = '0;
  logic [31:0] free_sum = '0;

  outcome_t    pending_q[$];
  block_t      held_q[$];
  int          fails    = 0;
  bit          calm     = 1'b0;
  bit          hold_rsp = 1'b0;

  // remove an entry, closing the gap
  function automatic void remove_region(int unsigned idx);
    fl_cnt--;
    for (int unsigned k = idx; k < fl_cnt; k++) begin
      fl_base[k] = fl_base[k+1];
      fl_size[k] = fl_size[k+1];
    end
  endfunction

  function automatic logic [31:0] take_first_fit(logic [31:0] len);
    logic [31:0] got;
    for (int unsigned i = 0; i < fl_cnt; i++) begin
      if (fl_size[i] >= len) begin
        got = fl_base[i];
        fl_base[i] += len;
        fl_size[i] -= len;
        free_sum -= len;
        if (fl_size[i] == 0) remove_region(i);
        return got;
      end
    end
    return '0;
  endfunction

  // returns 1 when the release is dropped
  function automatic bit give_back(logic [31:0] a, logic [31:0] len);
    int unsigned i;
    logic [31:0] e;
    e = a + len;
    for (i = 0; i < fl_cnt; i++)
      if (fl_base[i] > a) break;
    if (i > 0 && fl_base[i-1] + fl_size[i-1] == a) begin
      fl_size[i-1] += len;
      free_sum += len;
      if (i < fl_cnt && e == fl_base[i]) begin
        fl_size[i-1] += fl_size[i];
        remove_region(i);
      end
      return 1'b0;
    end
    if (i < fl_cnt && e == fl_base[i]) begin
      fl_base[i] = a;
      fl_size[i] += len;
      free_sum += len;
      return 1'b0;
    end
    if (fl_cnt < ffa_pkg::ENTRIES) begin
      for (int unsigned j = fl_cnt; j > i; j--) begin
        fl_base[j] = fl_base[j-1];
        fl_size[j] = fl_size[j-1];
      end
      fl_cnt++;
      if (fl_peak < fl_cnt) fl_peak = fl_cnt;
      fl_base[i] = a;
      fl_size[i] = len;
      free_sum += len;
      return 1'b0;
    end
    lost_n++;
    lost_b += len;
    return 1'b1;
  endfunction

  function automatic outcome_t predict_request(ffa_pkg::kind_e k, logic [31:0] a,
                                               logic [31:0] l);
    outcome_t o;
    logic [31:0] len;
    len = (k == ffa_pkg::KIND_ALLOC_PG || k == ffa_pkg::KIND_RELEASE_PG) ?
          ((l + ffa_pkg::PAGE_ADD) & ffa_pkg::PAGE_MASK) : l;
    o.addr = '0;
    o.st   = 1'b0;
    if (k == ffa_pkg::KIND_ALLOC || k == ffa_pkg::KIND_ALLOC_PG) begin
      o.addr = take_first_fit(len);
      if (o.addr != 0 && len != 0) held_q.push_back('{o.addr, len});
    end else begin
      o.st = give_back(a, len);
    end
    o.free   = free_sum;
    o.now    = fl_cnt[ffa_pkg::CW-1:0];
    o.peak   = fl_peak[ffa_pkg::CW-1:0];
    o.lost_n = lost_n;
    o.lost_b = lost_b;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    fails++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // send one beat, starting at a rising edge; returns at the edge it is taken, or after a random idle gap
  task automatic send_item(ffa_pkg::kind_e k, logic [31:0] a, logic [31:0] l);
    bit rdy;
    int gap;
    req.valid   <= 1'b1;
    req.kind    <= k;
    req.address <= a;
    req.length  <= l;
    do begin
      @(negedge clk_i);
      rdy = req.ready;
      @(posedge clk_i);
    end while (!rdy);
    pending_q.push_back(predict_request(k, a, l));
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // receiver with random stall bursts and the long hold-off
  initial begin
    rsp.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_rsp) begin
        rsp.ready <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_rsp = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(posedge clk_i);
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // response check on the stable half of the cycle
  always @(negedge clk_i) begin
    outcome_t w;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (pending_q.size() == 0) begin
        report("unexpected response beat", rsp.result_addr, 32'h0);
      end else begin
        w = pending_q.pop_front();
        if (rsp.result_addr !== w.addr) report("result_addr", rsp.result_addr, w.addr);
        if (rsp.status !== w.st) report("status", rsp.status, w.st);
        if (rsp.total_free !== w.free) report("total_free", rsp.total_free, w.free);
        if (rsp.regions_now !== w.now) report("regions_now", rsp.regions_now, w.now);
        if (rsp.regions_peak !== w.peak) report("regions_peak", rsp.regions_peak, w.peak);
        if (rsp.lost_regions !== w.lost_n)
          report("lost_regions", rsp.lost_regions, w.lost_n);
        if (rsp.lost_bytes_total !== w.lost_b)
          report("lost_bytes_total", rsp.lost_bytes_total, w.lost_b);
      end
    end
  end

  // extremes and special cases
  task automatic test_directed();
    send_item(ffa_pkg::KIND_ALLOC, 32'h0, 32'h10);
    send_item(ffa_pkg::KIND_RELEASE, 32'h1000_0000, 32'h0001_0000);
    send_item(ffa_pkg::KIND_ALLOC, 32'hffff_ffff, 32'h100);
    send_item(ffa_pkg::KIND_ALLOC, 32'h0, 32'h0);
    send_item(ffa_pkg::KIND_RELEASE, 32'h2000_0000, 32'h0);
    send_item(ffa_pkg::KIND_RELEASE, 32'h1000_0000, 32'h100);
    send_item(ffa_pkg::KIND_RELEASE, 32'h1001_0000, 32'h10);
    send_item(ffa_pkg::KIND_RELEASE, 32'h0f00_0000, 32'h10);
    send_item(ffa_pkg::KIND_RELEASE, 32'h0f00_0010, 32'h00ff_fff0);
    send_item(ffa_pkg::KIND_RELEASE, 32'hffff_fff0, 32'h20);
    send_item(ffa_pkg::KIND_RELEASE_PG, 32'h3000_0000, 32'h1);
    send_item(ffa_pkg::KIND_ALLOC_PG, 32'h0, 32'hffff_f001);
    send_item(ffa_pkg::KIND_ALLOC, 32'h0, 32'hffff_ffff);
    send_item(ffa_pkg::KIND_RELEASE_PG, 32'h5000_0000, 32'hffff_ffff);
    send_item(ffa_pkg::KIND_ALLOC_PG, 32'h0, 32'h1001);
    send_item(ffa_pkg::KIND_RELEASE, 32'h0, 32'h0);
    send_item(ffa_pkg::KIND_ALLOC, 32'h0, 32'h0);
    send_item(ffa_pkg::KIND_RELEASE, 32'h6000_0000, 32'hffff_ffff);
    send_item(ffa_pkg::KIND_ALLOC, 32'h0, 32'h8000_0000);
  endtask

  // long receiver hold-off while requests keep coming
  task automatic test_backpressure();
    hold_rsp = 1'b1;
    for (int n = 0; n < 6; n++)
      send_item(ffa_pkg::KIND_ALLOC, $urandom, $urandom_range(1, 32'h400));
  endtask

  // mostly alloc and matching release, some noise
  task automatic test_random(int count);
    int r;
    int p;
    block_t b;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 35) begin
        send_item($urandom_range(0, 1) ? ffa_pkg::KIND_ALLOC_PG : ffa_pkg::KIND_ALLOC,
                  $urandom, $urandom_range(0, 32'h3000));
      end else if (r < 70 && held_q.size() > 0) begin
        p = $urandom_range(0, held_q.size() - 1);
        b = held_q[p];
        held_q.delete(p);
        send_item(ffa_pkg::KIND_RELEASE, b.base, b.len);
      end else if (r < 85) begin
        send_item($urandom_range(0, 1) ? ffa_pkg::KIND_RELEASE_PG : ffa_pkg::KIND_RELEASE,
                  32'h1000_0000 + $urandom_range(0, 255) * 32'h1000,
                  $urandom_range(1, 4) * 32'h1000);
      end else begin
        send_item(ffa_pkg::kind_e'($urandom_range(0, 3)), $urandom, $urandom);
      end
    end
  endtask

  // a run of close regions, then merges on either side and allocation near them
  task automatic test_adjacent_runs();
    logic [31:0] a;
    a = 32'h8000_0000;
    for (int n = 0; n < 16; n++) begin
      send_item(ffa_pkg::KIND_RELEASE, a, 32'h10);
      a += 32'h100;
    end
    send_item(ffa_pkg::KIND_RELEASE, 32'h9000_0000, 32'h40);
    send_item(ffa_pkg::KIND_RELEASE_PG, 32'h9100_0000, 32'hffff_ffff);
    send_item(ffa_pkg::KIND_RELEASE, 32'h8000_0010, 32'h10);
    send_item(ffa_pkg::KIND_RELEASE, 32'h8000_0120, 32'he0);
    send_item(ffa_pkg::KIND_RELEASE, 32'h9000_0000, 32'h40);
    send_item(ffa_pkg::KIND_ALLOC, 32'h0, 32'h10);
    send_item(ffa_pkg::KIND_ALLOC_PG, 32'h0, 32'h1);
  endtask

  initial begin
    req.valid   = 1'b0;
    req.kind    = ffa_pkg::KIND_ALLOC;
    req.address = '0;
    req.length  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(250);
    calm = 1'b1;
    test_adjacent_runs();
    req.valid <= 1'b0;
    // drain, then let the block settle
    for (int c = 0; c < 200000 && pending_q.size() > 0; c++) @(posedge clk_i);
    repeat (4 * ffa_pkg::ENTRIES + 50) @(posedge clk_i);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #100_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
rtl/ffa_pkg.sv
rtl/ffa_if.sv
rtl/ffa_ram.sv
rtl/first_fit_free_list_allocator.sv
sim/tb_top.sv
